// File: rtl/rmvs_pkg.sv
// Shared constants and the queued item type for the running mean/variance block.
// Used by every module under rtl.
package rmvs_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int SAMPLE_W    = 32;
  localparam int ACC_W       = 64;
  localparam int ROOT_W      = ACC_W / 2;
  localparam int STEP_W      = $clog2(ACC_W + 1);
  localparam int SQ_STEP_W   = $clog2(ROOT_W + 1);
  localparam int OUT_DATA_W  = ((4 * SAMPLE_W + COUNT_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sample_valid;
    logic                last;
  } item_t;

endpackage

// File: rtl/rmvs_queue.sv
// Small FIFO of classified items between the front and back ends.
// Depends on rmvs_pkg (item_t, QUEUE_DEPTH).
module rmvs_queue import rmvs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/rmvs_front.sv
// Input stage: takes stream requests, drops rows that are neither counted nor final.
// Depends on rmvs_pkg (item_t).
module rmvs_front import rmvs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                push_valid,
  input  logic                push_ready,
  output item_t               push_item
);

  logic  held;
  item_t held_item;

  assign s_axis_tready = !held || push_ready;
  assign push_valid    = held;
  assign push_item     = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_axis_tready) begin
      held <= s_axis_tvalid && (s_axis_tuser || s_axis_tlast);
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      held_item.sample       <= s_axis_tdata;
      held_item.sample_valid <= s_axis_tuser;
      held_item.last         <= s_axis_tlast;
    end
  end

endmodule

// File: rtl/rmvs_div.sv
// Restoring divider, one quotient bit per cycle, run for a given number of steps.
// Depends on rmvs_pkg (ACC_W, COUNT_BITS, STEP_W).
module rmvs_div import rmvs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [STEP_W-1:0]   steps,
  input  logic [ACC_W-1:0]    dividend,
  input  logic [COUNT_BITS:0] divisor,
  output logic                done,
  output logic [ACC_W-1:0]    quotient
);

  logic [COUNT_BITS:0]   rem;
  logic [ACC_W-1:0]      sr;
  logic [COUNT_BITS:0]   dvs;
  logic [STEP_W-1:0]     left;
  logic                  busy;
  logic [COUNT_BITS+1:0] trial;
  logic [COUNT_BITS+1:0] diff;
  logic                  fits;

  assign trial    = {rem, sr[ACC_W-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign diff     = trial - {1'b0, dvs};
  assign quotient = sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sr  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[COUNT_BITS:0] : trial[COUNT_BITS:0];
      sr  <= {sr[ACC_W-2:0], fits};
    end
  end

endmodule

// File: rtl/rmvs_sqrt.sv
// Digit-by-digit floor square root, two radicand bits per cycle.
// Depends on rmvs_pkg (ACC_W, ROOT_W, SQ_STEP_W).
module rmvs_sqrt import rmvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [ROOT_W+1:0]    rem;
  logic [ACC_W-1:0]     rad;
  logic [SQ_STEP_W-1:0] left;
  logic                 busy;
  logic [ROOT_W+2:0]    rem_t;
  logic [ROOT_W+2:0]    trial;
  logic [ROOT_W+2:0]    diff;
  logic                 fits;

  assign rem_t = {rem[ROOT_W:0], rad[ACC_W-1:ACC_W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = (rem_t >= trial);
  assign diff  = rem_t - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= SQ_STEP_W'(ROOT_W);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == SQ_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      root <= '0;
      rad  <= radicand;
    end else if (busy) begin
      rem  <= fits ? diff[ROOT_W+1:0] : rem_t[ROOT_W+1:0];
      root <= {root[ROOT_W-2:0], fits};
      rad  <= {rad[ACC_W-3:0], 2'b00};
    end
  end

endmodule

// File: rtl/rmvs_core.sv
// Back end: Welford update per counted sample, final divide and sqrt if count > 1.
// Depends on rmvs_pkg, rmvs_div and rmvs_sqrt.
module rmvs_core import rmvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  item_t                 pop_item,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_UPD, S_MUL, S_ACC, S_FIN, S_FDIV, S_SQRT, S_EMIT
  } state_t;

  state_t state;

  logic signed [SAMPLE_W-1:0] run_mean;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic [ACC_W-1:0]           sum_sq_dev;
  logic [COUNT_BITS-1:0]      valid_count;

  logic signed [SAMPLE_W-1:0] xr;
  logic                       last_r;
  logic                       d_neg;
  logic [SAMPLE_W-1:0]        d_mag;
  logic [SAMPLE_W-1:0]        e_mag;
  logic [ACC_W-1:0]           prod;
  logic [ROOT_W-1:0]          std_r;

  logic [SAMPLE_W-1:0]        o_mean;
  logic [ROOT_W-1:0]          o_std;
  logic [SAMPLE_W-1:0]        o_min;
  logic [SAMPLE_W-1:0]        o_max;
  logic [COUNT_BITS-1:0]      o_count;
  logic                       o_status;
  logic                       o_valid;

  logic                       div_start;
  logic [STEP_W-1:0]          div_steps;
  logic [ACC_W-1:0]           div_dividend;
  logic [COUNT_BITS:0]        div_divisor;
  logic                       div_done;
  logic [ACC_W-1:0]           div_q;
  logic                       sq_start;
  logic [ACC_W-1:0]           sq_rad;
  logic                       sq_done;
  logic [ROOT_W-1:0]          sq_root;

  logic signed [SAMPLE_W:0]   d_full;
  logic signed [SAMPLE_W:0]   d_negd;
  logic signed [SAMPLE_W:0]   e_full;
  logic signed [SAMPLE_W:0]   e_negd;
  logic [SAMPLE_W-1:0]        q_lo;
  logic [ACC_W:0]             acc_sum;
  logic                       out_free;

  rmvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  rmvs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign pop_ready     = (state == S_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_status;
  assign m_axis_tdata  = OUT_DATA_W'({o_count, o_max, o_min, o_std, o_mean});
  assign out_free      = !o_valid || m_axis_tready;

  assign d_full  = {pop_item.sample[SAMPLE_W-1], pop_item.sample}
                 - {run_mean[SAMPLE_W-1], run_mean};
  assign d_negd  = -d_full;
  assign e_full  = {xr[SAMPLE_W-1], xr} - {run_mean[SAMPLE_W-1], run_mean};
  assign e_negd  = -e_full;
  assign q_lo    = div_q[SAMPLE_W-1:0];
  assign acc_sum = {1'b0, sum_sq_dev} + {1'b0, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      o_valid     <= 1'b0;
      div_start   <= 1'b0;
      sq_start    <= 1'b0;
      run_mean    <= '0;
      run_min     <= '0;
      run_max     <= '0;
      sum_sq_dev  <= '0;
      valid_count <= '0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      if (o_valid && m_axis_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            xr     <= pop_item.sample;
            last_r <= pop_item.last;
            if (pop_item.sample_valid && valid_count != '0) begin
              d_neg        <= d_full[SAMPLE_W];
              d_mag        <= d_full[SAMPLE_W] ? d_negd[SAMPLE_W-1:0] : d_full[SAMPLE_W-1:0];
              div_start    <= 1'b1;
              div_steps    <= STEP_W'(SAMPLE_W);
              div_dividend <= {(d_full[SAMPLE_W] ? d_negd[SAMPLE_W-1:0]
                                                 : d_full[SAMPLE_W-1:0]),
                               {(ACC_W - SAMPLE_W){1'b0}}};
              div_divisor  <= {1'b0, valid_count} + 1'b1;
              if ($signed(pop_item.sample) < run_min) begin
                run_min <= pop_item.sample;
              end
              if ($signed(pop_item.sample) > run_max) begin
                run_max <= pop_item.sample;
              end
              state <= S_DIV;
            end else begin
              if (pop_item.sample_valid) begin
                run_mean    <= pop_item.sample;
                run_min     <= pop_item.sample;
                run_max     <= pop_item.sample;
                valid_count <= COUNT_BITS'(1);
              end
              state <= pop_item.last ? S_FIN : S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            run_mean <= d_neg ? run_mean - q_lo : run_mean + q_lo;
            state    <= S_UPD;
          end
        end
        S_UPD: begin
          e_mag <= e_full[SAMPLE_W] ? e_negd[SAMPLE_W-1:0] : e_full[SAMPLE_W-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= ACC_W'(d_mag) * ACC_W'(e_mag);
          state <= S_ACC;
        end
        S_ACC: begin
          sum_sq_dev <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          if (valid_count != '1) begin
            valid_count <= valid_count + 1'b1;
          end
          state <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (valid_count <= COUNT_BITS'(1)) begin
            std_r <= '0;
            state <= S_EMIT;
          end else begin
            div_start    <= 1'b1;
            div_steps    <= STEP_W'(ACC_W);
            div_dividend <= sum_sq_dev;
            div_divisor  <= {1'b0, valid_count};
            state        <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            sq_start <= 1'b1;
            sq_rad   <= div_q;
            state    <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            std_r <= sq_root;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_valid     <= 1'b1;
            o_mean      <= run_mean;
            o_std       <= std_r;
            o_min       <= run_min;
            o_max       <= run_max;
            o_count     <= valid_count;
            o_status    <= (valid_count == '0);
            run_mean    <= '0;
            run_min     <= '0;
            run_max     <= '0;
            sum_sq_dev  <= '0;
            valid_count <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/running_mean_variance_stats.sv
// Running mean, population standard deviation, min and max over Q16.16 samples.
// The back end takes one item at a time; a counted sample after the first runs the
// 32-step shared divider for the mean, while skipped rows and the first sample do not.
// A final row with more than one counted sample adds a 64-step divide and a 32-step square root.
// Reset is synchronous and active high; it clears the statistics, queue and output stage.
// Depends on rmvs_pkg, rmvs_front, rmvs_queue and rmvs_core.
module running_mean_variance_stats import rmvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
  input  logic                  s_axis_tuser,   // [0] sample_valid
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // mean_out, std_out, min_out, max_out, count_out
  output logic                  m_axis_tuser    // [0] status
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  rmvs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  rmvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  rmvs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
